// ----- rtl/ccsoc_pkg.sv -----
// ----------------------------------------------------------------------------
// ccsoc_pkg
// Shared types and constants of the coulomb counting state-of-charge gauge.
// ----------------------------------------------------------------------------
`default_nettype none

package ccsoc_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int CUR_W    = 19;
    localparam int MV_W     = 16;
    localparam int MA_W     = 18;
    localparam int CAP_W    = 20;
    localparam int HOLD_W   = 11;
    localparam int SOC_W    = 27;

    // Stream widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    // Datapath widths
    localparam int DT_W     = 22;   // valid dt never exceeds one hour in ms
    localparam int SUM_W    = CUR_W + 1;
    localparam int PROD_W   = 44;
    localparam int DVD_W    = 48;
    localparam int DSR_W    = 24;
    localparam int ACC_W    = 50;
    localparam int HOLDMS_W = 27;

    localparam logic [TIME_W-1:0] MAX_DT_MS  = 32'd3600000;
    localparam logic [15:0]       MS_PER_MIN = 16'd60000;
    localparam logic [SOC_W-1:0]  FULL_SCALE = 27'd100000000;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_CAL    = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_MV   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 3'd7;

    // Register reset values
    localparam logic [CAP_W-1:0]  RST_CAPACITY = 20'd100000;
    localparam logic [MV_W-1:0]   RST_FULL_MV  = 16'd28800;
    localparam logic [MA_W-1:0]   RST_FULL_MA  = 18'd2000;
    localparam logic [HOLD_W-1:0] RST_HOLD_MIN = 11'd30;
    localparam logic [MV_W-1:0]   RST_EMPTY_MV = 16'd20000;
    localparam logic [MV_W-1:0]   RST_TOP_MV   = 16'd29200;
    localparam logic [SOC_W-1:0]  RST_FLOOR    = 27'd0;
    localparam logic [SOC_W-1:0]  RST_CEILING  = 27'd100000000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_SCALE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ACC,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul;
        logic scale;
        logic div_go;
        logic acc;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            need_div;
        logic            div_done;
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/ccsoc_div.sv -----
// ----------------------------------------------------------------------------
// ccsoc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ccsoc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ccsoc_pkg::DVD_W-1:0] i_dividend,
    input  wire logic [ccsoc_pkg::DSR_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [ccsoc_pkg::DVD_W-1:0]      o_quotient
);

    localparam int DVD_W = ccsoc_pkg::DVD_W;
    localparam int DSR_W = ccsoc_pkg::DSR_W;
    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;

    logic [DSR_W:0]   n_rem_sh;
    logic             n_ge;
    logic [DSR_W:0]   n_rem_diff;

    always_comb begin
        n_rem_sh   = {r_rem, r_quo[DVD_W-1]};
        n_ge       = n_rem_sh >= {1'b0, r_dsr};
        n_rem_diff = n_ge ? (n_rem_sh - {1'b0, r_dsr}) : n_rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], n_ge};
            r_rem <= n_rem_diff[DSR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- rtl/ccsoc_dp.sv -----
// ----------------------------------------------------------------------------
// ccsoc_dp
// Gauge datapath: configuration, gauge state, charge arithmetic and result.
// ----------------------------------------------------------------------------
`default_nettype none

module ccsoc_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire ccsoc_pkg::t_cmd                  i_cmd,
    output ccsoc_pkg::t_status                    o_status,
    input  wire logic [ccsoc_pkg::S_TDATA_W-1:0]  i_in_data,
    input  wire logic [ccsoc_pkg::S_TUSER_W-1:0]  i_in_user,
    input  wire logic                             i_cfg_we,
    input  wire logic [ccsoc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ccsoc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [ccsoc_pkg::M_TDATA_W-1:0]       o_out_data
);

    localparam int OP_W     = ccsoc_pkg::OP_W;
    localparam int TIME_W   = ccsoc_pkg::TIME_W;
    localparam int CUR_W    = ccsoc_pkg::CUR_W;
    localparam int MV_W     = ccsoc_pkg::MV_W;
    localparam int MA_W     = ccsoc_pkg::MA_W;
    localparam int CAP_W    = ccsoc_pkg::CAP_W;
    localparam int HOLD_W   = ccsoc_pkg::HOLD_W;
    localparam int SOC_W    = ccsoc_pkg::SOC_W;
    localparam int DT_W     = ccsoc_pkg::DT_W;
    localparam int SUM_W    = ccsoc_pkg::SUM_W;
    localparam int PROD_W   = ccsoc_pkg::PROD_W;
    localparam int DVD_W    = ccsoc_pkg::DVD_W;
    localparam int DSR_W    = ccsoc_pkg::DSR_W;
    localparam int ACC_W    = ccsoc_pkg::ACC_W;
    localparam int HOLDMS_W = ccsoc_pkg::HOLDMS_W;

    // Configuration registers
    logic [CAP_W-1:0]  r_capacity;
    logic [MV_W-1:0]   r_full_mv;
    logic [MA_W-1:0]   r_full_ma;
    logic [HOLD_W-1:0] r_hold_min;
    logic [MV_W-1:0]   r_empty_mv;
    logic [MV_W-1:0]   r_top_mv;
    logic [SOC_W-1:0]  r_floor;
    logic [SOC_W-1:0]  r_ceiling;

    // Gauge state
    logic [SOC_W-1:0]        r_soc;
    logic [TIME_W-1:0]       r_last_time;
    logic signed [CUR_W-1:0] r_prev_cur;
    logic                    r_tracking;
    logic [TIME_W-1:0]       r_start_time;
    logic                    r_recal;

    // Item being worked on
    logic [OP_W-1:0]         r_op;
    logic [TIME_W-1:0]       r_now;
    logic signed [CUR_W-1:0] r_cur;
    logic [MV_W-1:0]         r_mv;
    logic [SOC_W-1:0]        r_val;

    // Working registers
    logic [DT_W-1:0]          r_dt;
    logic                     r_dt_ok;
    logic signed [SUM_W-1:0]  r_csum;
    logic [HOLDMS_W-1:0]      r_hold_ms;
    logic                     r_cal_hi;
    logic                     r_cal_lo;
    logic [MV_W-1:0]          r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic [DVD_W-1:0]         r_dvd;
    logic [DSR_W-1:0]         r_dsr;
    logic                     r_neg;
    logic signed [ACC_W-1:0]  r_acc;

    // Result register
    logic [SOC_W-1:0] r_out_soc;
    logic             r_out_full;
    logic             r_out_recal;

    logic             div_done;
    logic [DVD_W-1:0] div_quo;

    function automatic logic [SOC_W-1:0] clamp_soc(
        input logic signed [ACC_W-1:0] s,
        input logic [SOC_W-1:0]        lo,
        input logic [SOC_W-1:0]        hi
    );
        logic signed [ACC_W-1:0] t;
        t = s;
        if (t > $signed({{(ACC_W-SOC_W){1'b0}}, hi})) begin
            t = $signed({{(ACC_W-SOC_W){1'b0}}, hi});
        end
        if (t < $signed({{(ACC_W-SOC_W){1'b0}}, lo})) begin
            t = $signed({{(ACC_W-SOC_W){1'b0}}, lo});
        end
        return t[SOC_W-1:0];
    endfunction

    ccsoc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (r_dvd),
        .i_divisor  (r_dsr),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_status.op       = r_op;
    assign o_status.need_div = ((r_op == ccsoc_pkg::OP_SAMPLE) && r_dt_ok) ||
                               ((r_op == ccsoc_pkg::OP_CAL) && !r_cal_hi && !r_cal_lo);
    assign o_status.div_done = div_done;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= ccsoc_pkg::RST_CAPACITY;
            r_full_mv  <= ccsoc_pkg::RST_FULL_MV;
            r_full_ma  <= ccsoc_pkg::RST_FULL_MA;
            r_hold_min <= ccsoc_pkg::RST_HOLD_MIN;
            r_empty_mv <= ccsoc_pkg::RST_EMPTY_MV;
            r_top_mv   <= ccsoc_pkg::RST_TOP_MV;
            r_floor    <= ccsoc_pkg::RST_FLOOR;
            r_ceiling  <= ccsoc_pkg::RST_CEILING;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ccsoc_pkg::REG_CAPACITY: r_capacity <= i_cfg_data[CAP_W-1:0];
                ccsoc_pkg::REG_FULL_MV:  r_full_mv  <= i_cfg_data[MV_W-1:0];
                ccsoc_pkg::REG_FULL_MA:  r_full_ma  <= i_cfg_data[MA_W-1:0];
                ccsoc_pkg::REG_HOLD_MIN: r_hold_min <= i_cfg_data[HOLD_W-1:0];
                ccsoc_pkg::REG_EMPTY_MV: r_empty_mv <= i_cfg_data[MV_W-1:0];
                ccsoc_pkg::REG_TOP_MV:   r_top_mv   <= i_cfg_data[MV_W-1:0];
                ccsoc_pkg::REG_FLOOR:    r_floor    <= i_cfg_data[SOC_W-1:0];
                ccsoc_pkg::REG_CEILING:  r_ceiling  <= i_cfg_data[SOC_W-1:0];
                default: ;
            endcase
        end
    end

    // Arithmetic steps
    logic [TIME_W-1:0]        n_dt;
    logic signed [42:0]       n_prod_smp;
    logic [42:0]              n_prod_cal;
    logic [PROD_W-1:0]        n_mag;
    logic [DVD_W-1:0]         n_mag48;
    logic [CAP_W-1:0]         n_cap_eff;
    logic signed [ACC_W-1:0]  n_q_s;
    logic signed [ACC_W-1:0]  n_base;

    always_comb begin
        n_dt       = r_now - r_last_time;
        n_prod_smp = r_csum * $signed({1'b0, r_dt});
        n_prod_cal = 43'(r_diff) * 43'(ccsoc_pkg::FULL_SCALE);
        n_mag      = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        n_mag48    = DVD_W'(n_mag);
        n_cap_eff  = (r_capacity == '0) ? CAP_W'(1) : r_capacity;
        n_q_s      = $signed({{(ACC_W-DVD_W){1'b0}}, div_quo});
        n_base     = (r_op == ccsoc_pkg::OP_SAMPLE) ?
                     $signed({{(ACC_W-SOC_W){1'b0}}, r_soc}) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_user;
            r_now <= i_in_data[31:0];
            r_cur <= $signed(i_in_data[50:32]);
            r_mv  <= i_in_data[66:51];
            r_val <= i_in_data[93:67];
        end
        if (i_cmd.prep) begin
            r_dt      <= n_dt[DT_W-1:0];
            r_dt_ok   <= (n_dt != '0) && (n_dt <= ccsoc_pkg::MAX_DT_MS);
            r_csum    <= $signed({r_cur[CUR_W-1], r_cur}) +
                         $signed({r_prev_cur[CUR_W-1], r_prev_cur});
            r_hold_ms <= HOLDMS_W'(HOLDMS_W'(r_hold_min) *
                                   HOLDMS_W'(ccsoc_pkg::MS_PER_MIN));
            r_cal_hi  <= r_mv >= r_top_mv;
            r_cal_lo  <= r_mv <= r_empty_mv;
            r_diff    <= r_mv - r_empty_mv;
        end
        if (i_cmd.mul) begin
            if (r_op == ccsoc_pkg::OP_SAMPLE) begin
                r_prod <= $signed({n_prod_smp[42], n_prod_smp});
            end else begin
                r_prod <= $signed({1'b0, n_prod_cal});
            end
        end
        // Samples: charge scaled by 125 as shift-and-add, divisor 9 * capacity; calibrations divide by the voltage span
        if (i_cmd.scale) begin
            if (r_op == ccsoc_pkg::OP_SAMPLE) begin
                r_dvd <= (n_mag48 << 7) - (n_mag48 << 2) + n_mag48;
                r_neg <= r_prod[PROD_W-1];
                r_dsr <= {1'b0, n_cap_eff, 3'b000} + DSR_W'(n_cap_eff);
            end else begin
                r_dvd <= n_mag48;
                r_neg <= 1'b0;
                r_dsr <= DSR_W'(r_top_mv - r_empty_mv);
            end
        end
        if (i_cmd.acc) begin
            r_acc <= n_base + (r_neg ? -n_q_s : n_q_s);
        end
    end

    // Commit of the item into the gauge state
    logic [CUR_W-1:0]  n_cur_mag;
    logic              n_cond;
    logic [TIME_W-1:0] n_start_eff;
    logic [TIME_W-1:0] n_elapsed;
    logic              n_hit;

    logic [SOC_W-1:0]        n_soc;
    logic [TIME_W-1:0]       n_last_time;
    logic signed [CUR_W-1:0] n_prev_cur;
    logic                    n_tracking;
    logic [TIME_W-1:0]       n_start_time;
    logic                    n_recal;

    always_comb begin
        n_cur_mag   = r_cur[CUR_W-1] ? (~r_cur + 1'b1) : r_cur;
        n_cond      = (r_mv >= r_full_mv) && (n_cur_mag < {1'b0, r_full_ma});
        n_start_eff = r_tracking ? r_start_time : r_now;
        n_elapsed   = r_now - n_start_eff;
        n_hit       = n_cond && !r_recal &&
                      (n_elapsed >= TIME_W'(r_hold_ms));

        n_soc        = r_soc;
        n_last_time  = r_last_time;
        n_prev_cur   = r_prev_cur;
        n_tracking   = r_tracking;
        n_start_time = r_start_time;
        n_recal      = r_recal;

        case (r_op)
            ccsoc_pkg::OP_SAMPLE: begin
                if (r_dt_ok) begin
                    if (n_cond) begin
                        n_tracking   = 1'b1;
                        n_start_time = n_start_eff;
                    end else begin
                        n_tracking   = 1'b0;
                        n_start_time = '0;
                    end
                    if (n_hit) begin
                        n_recal = 1'b1;
                        n_soc   = clamp_soc($signed({{(ACC_W-SOC_W){1'b0}}, r_ceiling}),
                                            r_floor, r_ceiling);
                    end else begin
                        n_soc   = clamp_soc(r_acc, r_floor, r_ceiling);
                    end
                end
                n_prev_cur  = r_cur;
                n_last_time = r_now;
            end
            ccsoc_pkg::OP_CAL: begin
                if (r_cal_hi) begin
                    n_soc = r_ceiling;
                end else if (r_cal_lo) begin
                    n_soc = r_floor;
                end else begin
                    n_soc = clamp_soc(r_acc, r_floor, r_ceiling);
                end
                n_recal    = 1'b0;
                n_prev_cur = '0;
            end
            ccsoc_pkg::OP_LOAD: begin
                n_soc = clamp_soc($signed({{(ACC_W-SOC_W){1'b0}}, r_val}),
                                  r_floor, r_ceiling);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soc        <= '0;
            r_last_time  <= '0;
            r_prev_cur   <= '0;
            r_tracking   <= 1'b0;
            r_start_time <= '0;
            r_recal      <= 1'b0;
        end else if (i_cmd.commit) begin
            r_soc        <= n_soc;
            r_last_time  <= n_last_time;
            r_prev_cur   <= n_prev_cur;
            r_tracking   <= n_tracking;
            r_start_time <= n_start_time;
            r_recal      <= n_recal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_soc   <= n_soc;
            r_out_full  <= n_tracking;
            r_out_recal <= n_recal;
        end
    end

    assign o_out_data = {3'b000, r_out_recal, r_out_full, r_out_soc};

endmodule

`default_nettype wire

// ----- rtl/ccsoc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ccsoc_ctrl
// Gauge sequencer: steps one item through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ccsoc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire ccsoc_pkg::t_status i_status,
    output ccsoc_pkg::t_cmd         o_cmd
);

    ccsoc_pkg::t_state r_state;
    ccsoc_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              out_free;
    logic              run_op;

    assign out_free = !r_out_valid || i_out_ready;
    assign run_op   = (i_status.op == ccsoc_pkg::OP_SAMPLE) ||
                      (i_status.op == ccsoc_pkg::OP_CAL);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ccsoc_pkg::S_IDLE:     if (i_in_valid) n_state = ccsoc_pkg::S_PREP;
            ccsoc_pkg::S_PREP:     n_state = run_op ? ccsoc_pkg::S_MUL : ccsoc_pkg::S_COMMIT;
            ccsoc_pkg::S_MUL:      n_state = i_status.need_div ? ccsoc_pkg::S_SCALE
                                                               : ccsoc_pkg::S_COMMIT;
            ccsoc_pkg::S_SCALE:    n_state = ccsoc_pkg::S_DIV_GO;
            ccsoc_pkg::S_DIV_GO:   n_state = ccsoc_pkg::S_DIV_WAIT;
            ccsoc_pkg::S_DIV_WAIT: if (i_status.div_done) n_state = ccsoc_pkg::S_ACC;
            ccsoc_pkg::S_ACC:      n_state = ccsoc_pkg::S_COMMIT;
            ccsoc_pkg::S_COMMIT:   if (out_free) n_state = ccsoc_pkg::S_IDLE;
            default:               n_state = ccsoc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ccsoc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ccsoc_pkg::S_PREP:   o_cmd.prep   = 1'b1;
            ccsoc_pkg::S_MUL:    o_cmd.mul    = i_status.need_div;
            ccsoc_pkg::S_SCALE:  o_cmd.scale  = 1'b1;
            ccsoc_pkg::S_DIV_GO: o_cmd.div_go = 1'b1;
            ccsoc_pkg::S_ACC:    o_cmd.acc    = 1'b1;
            ccsoc_pkg::S_COMMIT: o_cmd.commit = out_free;
            default: ;
        endcase
    end

    // Hold the result until taken; a new commit refills the slot
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ccsoc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/coulomb_counter_soc.sv -----
// ----------------------------------------------------------------------------
// coulomb_counter_soc: coulomb counting state-of-charge gauge, micro-percent
// Items are worked on one at a time: a sample or calibration that divides
// passes through the serial divider before its result is registered; one that
// skips the divide, a load or an unused op does not. The next item is taken
// the cycle after the result is registered, later while the result waits.
// Synchronous active-low reset clears the gauge state and restores register
// defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module coulomb_counter_soc (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    // Input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // tdata, from bit 0: now_ms[31:0], current_ma[50:32], voltage_mv[66:51],
    //                    soc_value[93:67], zero pad [95:94]
    input  wire logic [ccsoc_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: op[1:0]
    input  wire logic [ccsoc_pkg::S_TUSER_W-1:0]  s_tuser,

    // Result items
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // tdata, from bit 0: soc_upct[26:0], full_flag[27], recal_flag[28],
    //                    zero pad [31:29]
    output logic [ccsoc_pkg::M_TDATA_W-1:0]       m_tdata,

    // Configuration writes
    input  wire logic                             i_cfg_we,
    input  wire logic [ccsoc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ccsoc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // The sequencer walks each item through those of these steps it needs:
    //   accept  - latch the item
    //   prep    - elapsed time, current sum, hold time in ms, voltage rails
    //   mul     - current sum times dt, or voltage span times full scale
    //   scale   - take magnitude, times 125, divisor 9 * capacity (or span)
    //   div     - one quotient bit per cycle, serial over the dividend
    //   acc     - add signed charge to the stored SOC (calibration: quotient)
    //   commit  - full-charge detector, clamp, state update, result register
    // The commit waits while the result register still holds an untaken item,
    // so no item is ever dropped or overwritten.

    ccsoc_pkg::t_cmd    cmd;
    ccsoc_pkg::t_status status;

    ccsoc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Config goes straight to datapath; user writes only while idle, unenforced
    ccsoc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (s_tdata),
        .i_in_user   (s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: coulomb_counter_soc
// Streams samples, voltage calibrations and SOC loads into the gauge. Each
// accepted item is run through an in-bench model of the gauge, and every
// result item is checked against it in order. Runs cover directed corners,
// register extremes, randomised settings with random idling on both sides,
// and one unbroken stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int OP_W       = ccsoc_pkg::OP_W;
    localparam int TIME_W     = ccsoc_pkg::TIME_W;
    localparam int CUR_W      = ccsoc_pkg::CUR_W;
    localparam int MV_W       = ccsoc_pkg::MV_W;
    localparam int MA_W       = ccsoc_pkg::MA_W;
    localparam int CAP_W      = ccsoc_pkg::CAP_W;
    localparam int HOLD_W     = ccsoc_pkg::HOLD_W;
    localparam int SOC_W      = ccsoc_pkg::SOC_W;
    localparam int S_TDATA_W  = ccsoc_pkg::S_TDATA_W;
    localparam int S_TUSER_W  = ccsoc_pkg::S_TUSER_W;
    localparam int M_TDATA_W  = ccsoc_pkg::M_TDATA_W;
    localparam int CFG_IDX_W  = ccsoc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ccsoc_pkg::CFG_DATA_W;

    localparam logic [TIME_W-1:0] MAX_DT_MS  = ccsoc_pkg::MAX_DT_MS;
    localparam logic [15:0]       MS_PER_MIN = ccsoc_pkg::MS_PER_MIN;
    localparam logic [SOC_W-1:0]  FULL_SCALE = ccsoc_pkg::FULL_SCALE;

    localparam logic [OP_W-1:0] OP_SAMPLE = ccsoc_pkg::OP_SAMPLE;
    localparam logic [OP_W-1:0] OP_CAL    = ccsoc_pkg::OP_CAL;
    localparam logic [OP_W-1:0] OP_LOAD   = ccsoc_pkg::OP_LOAD;

    // Spare op code: the gauge must report its state and change nothing
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Trapezoid charge in micro-percent: (I0 + I1) * dt * 1e8 / (2 * 3.6e6 * C)
    // reduces to (I0 + I1) * dt * 125 / (9 * C)
    localparam longint CHARGE_MUL = 125;
    localparam longint CHARGE_DIV = 9;

    typedef struct packed {
        logic [SOC_W-1:0] soc;
        logic             full;
        logic             recal;
    } t_gauge_out;

    typedef struct packed {
        logic [CAP_W-1:0]  capacity;
        logic [MV_W-1:0]   full_mv;
        logic [MA_W-1:0]   full_ma;
        logic [HOLD_W-1:0] hold_min;
        logic [MV_W-1:0]   empty_mv;
        logic [MV_W-1:0]   top_mv;
        logic [SOC_W-1:0]  soc_min;
        logic [SOC_W-1:0]  soc_max;
    } t_gauge_cfg;

    // Clock, reset and every block input hold a known value from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [S_TUSER_W-1:0]  s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Register mirror and gauge state of the in-bench model
    t_gauge_cfg               cfg;
    logic [SOC_W-1:0]         gauge_soc;
    logic [TIME_W-1:0]        gauge_last_ms;
    logic signed [CUR_W-1:0]  gauge_prev_ma;
    logic                     gauge_tracking;
    logic [TIME_W-1:0]        gauge_track_t0;
    logic                     gauge_recal;

    // Predicted results still owed by the gauge, oldest first
    t_gauge_out pending_soc[$];

    int   mismatches = 0;
    int   items_sent = 0;
    logic calm       = 1'b0;  // high: neither side idles
    t_gauge_out want;
    t_gauge_out got;

    coulomb_counter_soc dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Gauge model
    // ------------------------------------------------------------------------

    // Hold the SOC within the window; the floor wins when the window is inverted
    function automatic logic [SOC_W-1:0] bound_soc(input longint s);
        if (s > longint'(cfg.soc_max)) s = longint'(cfg.soc_max);
        if (s < longint'(cfg.soc_min)) s = longint'(cfg.soc_min);
        return s[SOC_W-1:0];
    endfunction

    function automatic t_gauge_out predict_gauge(
        input logic [OP_W-1:0]         op,
        input logic [TIME_W-1:0]       now,
        input logic signed [CUR_W-1:0] cur,
        input logic [MV_W-1:0]         mv,
        input logic [SOC_W-1:0]        val
    );
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] held;
        longint            cap;
        longint            charge;
        longint            level;
        longint            mag;
        t_gauge_out        r;
        case (op)
            OP_SAMPLE: begin
                dt = now - gauge_last_ms;
                // A zero or over-long gap only updates the timestamp and previous current
                if (dt != 0 && dt <= MAX_DT_MS) begin
                    cap    = (cfg.capacity == 0) ? 64'sd1 : longint'(cfg.capacity);
                    charge = (longint'(gauge_prev_ma) + longint'(cur)) * longint'(dt)
                             * CHARGE_MUL;
                    level  = longint'(gauge_soc) + charge / (CHARGE_DIV * cap);
                    mag    = (cur < 0) ? -longint'(cur) : longint'(cur);
                    if (mv >= cfg.full_mv && mag < longint'(cfg.full_ma)) begin
                        if (!gauge_tracking) begin
                            gauge_tracking = 1'b1;
                            gauge_track_t0 = now;
                        end
                        held = now - gauge_track_t0;
                        if (longint'(held) >= longint'(cfg.hold_min) * longint'(MS_PER_MIN)
                                && !gauge_recal) begin
                            level       = longint'(cfg.soc_max);
                            gauge_recal = 1'b1;
                        end
                    end else begin
                        gauge_tracking = 1'b0;
                        gauge_track_t0 = '0;
                    end
                    gauge_soc = bound_soc(level);
                end
                gauge_prev_ma = cur;
                gauge_last_ms = now;
            end
            OP_CAL: begin
                if (mv >= cfg.top_mv) begin
                    gauge_soc = cfg.soc_max;
                end else if (mv <= cfg.empty_mv) begin
                    gauge_soc = cfg.soc_min;
                end else begin
                    gauge_soc = bound_soc(longint'(mv - cfg.empty_mv) * longint'(FULL_SCALE)
                                          / longint'(cfg.top_mv - cfg.empty_mv));
                end
                gauge_recal   = 1'b0;
                gauge_prev_ma = '0;
            end
            OP_LOAD: begin
                gauge_soc = bound_soc(longint'(val));
            end
            default: begin
            end
        endcase
        r.soc   = gauge_soc;
        r.full  = gauge_tracking;
        r.recal = gauge_recal;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and in-order checking
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 22);
    end

    task automatic flag_mismatch(input string what, input t_gauge_out exp_v,
                                 input t_gauge_out act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected soc=%0d full=%0d recal=%0d, got soc=%0d full=%0d recal=%0d",
                     $time, what, exp_v.soc, exp_v.full, exp_v.recal,
                     act_v.soc, act_v.full, act_v.recal);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            got.soc   = m_tdata[SOC_W-1:0];
            got.full  = m_tdata[SOC_W];
            got.recal = m_tdata[SOC_W+1];
            if (pending_soc.size() == 0) begin
                flag_mismatch("result with nothing outstanding", '0, got);
            end else begin
                want = pending_soc.pop_front();
                if (got.soc !== want.soc || got.full !== want.full
                        || got.recal !== want.recal)
                    flag_mismatch("result mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------------

    // Present one item, hold it until taken, then log the predicted result
    task automatic send_item(
        input logic [OP_W-1:0]         op,
        input logic [TIME_W-1:0]       now,
        input logic signed [CUR_W-1:0] cur,
        input logic [MV_W-1:0]         mv,
        input logic [SOC_W-1:0]        val
    );
        // Idle now and then, long enough to land anywhere in the gauge's work
        if (!calm && $urandom_range(0, 99) < 22) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, val, mv, cur, now};
        do @(posedge i_clk); while (!s_tready);
        pending_soc.push_back(predict_gauge(op, now, cur, mv, val));
        items_sent++;
    endtask

    // Drop valid and wait for the gauge to drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_soc.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Write every register back to back; the gauge must be idle
    task automatic program_gauge(input t_gauge_cfg c);
        write_reg(ccsoc_pkg::REG_CAPACITY, c.capacity);
        write_reg(ccsoc_pkg::REG_FULL_MV,  c.full_mv);
        write_reg(ccsoc_pkg::REG_FULL_MA,  c.full_ma);
        write_reg(ccsoc_pkg::REG_HOLD_MIN, c.hold_min);
        write_reg(ccsoc_pkg::REG_EMPTY_MV, c.empty_mv);
        write_reg(ccsoc_pkg::REG_TOP_MV,   c.top_mv);
        write_reg(ccsoc_pkg::REG_FLOOR,    c.soc_min);
        write_reg(ccsoc_pkg::REG_CEILING,  c.soc_max);
        i_cfg_we <= 1'b0;
        cfg = c;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus generators
    // ------------------------------------------------------------------------

    function automatic logic signed [CUR_W-1:0] pick_current();
        int pick;
        int mag;
        pick = $urandom_range(0, 99);
        if (pick < 40 && cfg.full_ma != 0)
            mag = $urandom_range(0, cfg.full_ma - 1);  // inside the full band
        else if (pick < 50)
            mag = 200000;
        else
            mag = $urandom_range(0, 200000);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Magnitude strictly under the full-detect current; full_ma must be non-zero
    function automatic logic signed [CUR_W-1:0] band_current();
        int mag;
        mag = $urandom_range(0, cfg.full_ma - 1);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic [MV_W-1:0] pick_voltage(input logic high_band);
        if (high_band)
            return $urandom_range(cfg.full_mv, 16'hFFFF);
        return $urandom_range(0, 16'hFFFF);
    endfunction

    task automatic send_sample_random();
        int                pick;
        logic [TIME_W-1:0] dt;
        pick = $urandom_range(0, 99);
        if (pick < 45)      dt = $urandom_range(1, 2000);
        else if (pick < 70) dt = $urandom_range(2001, 600000);
        else if (pick < 82) dt = $urandom_range(600001, MAX_DT_MS);
        else if (pick < 85) dt = MAX_DT_MS;
        else if (pick < 88) dt = 1;
        else if (pick < 93) dt = 0;
        else if (pick < 97) dt = MAX_DT_MS + 1 + $urandom_range(0, 100000000);
        else                dt = $urandom();
        send_item(OP_SAMPLE, gauge_last_ms + dt, pick_current(),
                  pick_voltage($urandom_range(0, 99) < 45), $urandom_range(0, FULL_SCALE));
    endtask

    task automatic send_cal_random();
        int v;
        if ($urandom_range(0, 99) < 30) begin
            case ($urandom_range(0, 5))
                0:       v = cfg.empty_mv;
                1:       v = cfg.top_mv;
                2:       v = int'(cfg.empty_mv) + 1;
                3:       v = int'(cfg.top_mv) - 1;
                4:       v = 0;
                default: v = 65535;
            endcase
            if (v < 0)     v = 0;
            if (v > 65535) v = 65535;
        end else begin
            v = $urandom_range(0, 65535);
        end
        send_item(OP_CAL, $urandom(), pick_current(), v, $urandom_range(0, FULL_SCALE));
    endtask

    task automatic send_load_random();
        int v;
        if ($urandom_range(0, 99) < 25) begin
            case ($urandom_range(0, 5))
                0:       v = 0;
                1:       v = FULL_SCALE;
                2:       v = cfg.soc_min;
                3:       v = cfg.soc_max;
                4:       v = int'(cfg.soc_min) - 1;
                default: v = int'(cfg.soc_max) + 1;
            endcase
            if (v < 0)                v = 0;
            if (v > int'(FULL_SCALE)) v = FULL_SCALE;
        end else begin
            v = $urandom_range(0, FULL_SCALE);
        end
        send_item(OP_LOAD, $urandom(), pick_current(), $urandom_range(0, 65535), v);
    endtask

    // Hold the full condition for the whole hold time, in steps of at most an
    // hour, so that recalibration is reached; optionally rearm it first
    task automatic send_charge_top();
        longint hold_ms;
        longint stride;
        int     n;
        hold_ms = longint'(cfg.hold_min) * longint'(MS_PER_MIN);
        n       = int'(hold_ms / longint'(MAX_DT_MS)) + $urandom_range(2, 4);
        stride  = hold_ms / (n - 1) + 1 + $urandom_range(0, 500);
        if (stride > longint'(MAX_DT_MS)) stride = MAX_DT_MS;
        if ($urandom_range(0, 1))
            send_item(OP_CAL, gauge_last_ms, '0, $urandom_range(0, 65535), '0);
        repeat (n)
            send_item(OP_SAMPLE, gauge_last_ms + stride[TIME_W-1:0], band_current(),
                      pick_voltage(1'b1), $urandom_range(0, FULL_SCALE));
    endtask

    task automatic send_random_step();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4 && cfg.full_ma != 0)
            send_charge_top();
        else if (pick < 72)
            send_sample_random();
        else if (pick < 84)
            send_cal_random();
        else if (pick < 97)
            send_load_random();
        else
            send_item(OP_UNUSED, $urandom(), pick_current(), $urandom_range(0, 65535),
                      $urandom_range(0, FULL_SCALE));
    endtask

    function automatic t_gauge_cfg pick_settings();
        int         pick;
        t_gauge_cfg c;
        pick = $urandom_range(0, 99);
        if (pick < 5)       c.capacity = 0;
        else if (pick < 12) c.capacity = 1;
        else if (pick < 20) c.capacity = 1000000;
        else                c.capacity = $urandom_range(1, 1000000) >> $urandom_range(0, 12);

        pick = $urandom_range(0, 99);
        if (pick < 10)      c.full_mv = 0;
        else if (pick < 15) c.full_mv = 16'hFFFF;
        else                c.full_mv = $urandom_range(20000, 65535);

        pick = $urandom_range(0, 99);
        if (pick < 8)       c.full_ma = 0;
        else if (pick < 13) c.full_ma = 200000;
        else                c.full_ma = $urandom_range(1, 50000);

        pick = $urandom_range(0, 99);
        if (pick < 30)      c.hold_min = 0;
        else if (pick < 70) c.hold_min = $urandom_range(1, 5);
        else if (pick < 85) c.hold_min = $urandom_range(6, 60);
        else if (pick < 93) c.hold_min = 1440;
        else                c.hold_min = $urandom_range(0, 1440);

        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            c.empty_mv = $urandom_range(0, 65535);
            c.top_mv   = c.empty_mv;
        end else if (pick < 8) begin
            c.empty_mv = $urandom_range(1, 65535);
            c.top_mv   = $urandom_range(0, c.empty_mv - 1);
        end else if (pick < 13) begin
            c.empty_mv = 0;
            c.top_mv   = 16'hFFFF;
        end else begin
            c.empty_mv = $urandom_range(0, 60000);
            c.top_mv   = c.empty_mv + $urandom_range(1, 65535 - c.empty_mv);
        end

        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            c.soc_max = $urandom_range(0, FULL_SCALE - 1);
            c.soc_min = $urandom_range(c.soc_max + 1, FULL_SCALE);
        end else if (pick < 10) begin
            c.soc_min = $urandom_range(0, FULL_SCALE);
            c.soc_max = c.soc_min;
        end else if (pick < 25) begin
            c.soc_min = 0;
            c.soc_max = FULL_SCALE;
        end else begin
            c.soc_min = $urandom_range(0, 30000000);
            c.soc_max = $urandom_range(60000000, FULL_SCALE);
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset register values; walk every op, the time-gap limits and the
    // full-charge detector by hand
    task automatic test_directed_ops();
        logic [TIME_W-1:0] t0;
        t0 = 32'd1000000;
        send_item(OP_UNUSED, 32'd0, 19'sd0, 16'd0, '0);            // reset state
        send_item(OP_SAMPLE, 32'd0, 19'sd200000, 16'd0, '0);       // no time elapsed
        send_item(OP_SAMPLE, 32'd1000, 19'sd200000, 16'd20000, '0);
        send_item(OP_SAMPLE, 32'd3601000, -19'sd200000, 16'hFFFF, '0); // exactly an hour
        send_item(OP_SAMPLE, 32'd7201001, -19'sd1, 16'd0, '0);     // one ms too long
        send_item(OP_SAMPLE, 32'hFFFF_FFF0, 19'sd0, 16'd0, '0);    // far too long
        send_item(OP_SAMPLE, 32'h0000_0010, -19'sd200000, 16'd0, '0); // timestamp wraps
        send_item(OP_LOAD, $urandom(), 19'sd0, 16'd0, FULL_SCALE);
        send_item(OP_LOAD, $urandom(), 19'sd0, 16'd0, 27'd0);
        send_item(OP_LOAD, $urandom(), 19'sd0, 16'd0, 27'd50000000);
        send_item(OP_CAL, 32'd0, 19'sd0, 16'd0, '0);               // below empty
        send_item(OP_CAL, 32'd0, 19'sd0, 16'hFFFF, '0);            // above top
        send_item(OP_CAL, 32'd0, 19'sd0, ccsoc_pkg::RST_EMPTY_MV, '0);
        send_item(OP_CAL, 32'd0, 19'sd0, ccsoc_pkg::RST_TOP_MV, '0);
        send_item(OP_CAL, 32'd0, 19'sd0, 16'd24600, '0);
        send_item(OP_CAL, 32'd0, 19'sd0, ccsoc_pkg::RST_EMPTY_MV + 16'd1, '0);
        // Full condition: start tracking, hold 30 minutes, recalibrate once
        send_item(OP_SAMPLE, t0, 19'sd1999, ccsoc_pkg::RST_FULL_MV, '0);
        send_item(OP_SAMPLE, t0 + 32'd1800000, -19'sd1999, 16'hFFFF, '0);
        send_item(OP_SAMPLE, t0 + 32'd1801000, 19'sd0, 16'd30000, '0);
        send_item(OP_SAMPLE, t0 + 32'd1802000, 19'sd2000, 16'd30000, '0); // current too high
        send_item(OP_SAMPLE, t0 + 32'd1803000, 19'sd0, ccsoc_pkg::RST_FULL_MV - 16'd1, '0);
        send_item(OP_CAL, 32'd0, 19'sd0, 16'd25000, '0);           // rearm recalibration
        send_item(OP_UNUSED, 32'hFFFF_FFFF, -19'sd1, 16'hFFFF, 27'h7FF_FFFF);
        settle();
    endtask

    // Zero capacity, zero hold, a one-day hold, inverted windows and a
    // detector that can never fire
    task automatic test_register_extremes();
        program_gauge('{capacity: '0, full_mv: '0, full_ma: 18'd200000, hold_min: '0,
                        empty_mv: '0, top_mv: 16'hFFFF, soc_min: '0, soc_max: FULL_SCALE});
        repeat (10) send_random_step();
        send_charge_top();
        settle();
        program_gauge('{capacity: 20'd1000000, full_mv: 16'hFFFF, full_ma: '0,
                        hold_min: 11'd1440, empty_mv: 16'hFFFF, top_mv: '0,
                        soc_min: FULL_SCALE, soc_max: '0});
        repeat (12) send_random_step();
        settle();
        program_gauge('{capacity: 20'd1, full_mv: '0, full_ma: 18'd200000,
                        hold_min: 11'd1440, empty_mv: 16'd30000, top_mv: 16'd30001,
                        soc_min: 27'd50000000, soc_max: 27'd50000000});
        send_charge_top();
        repeat (6) send_random_step();
        settle();
    endtask

    task automatic test_random_traffic();
        int first;
        repeat (9) begin
            program_gauge(pick_settings());
            first = items_sent;
            while (items_sent - first < 150) send_random_step();
            settle();
        end
    endtask

    // Back-to-back items with the receiver always ready
    task automatic test_unbroken_stream();
        int first;
        program_gauge(pick_settings());
        calm  = 1'b1;
        first = items_sent;
        while (items_sent - first < 250) send_random_step();
        settle();
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        cfg = '{capacity: ccsoc_pkg::RST_CAPACITY, full_mv: ccsoc_pkg::RST_FULL_MV,
                full_ma: ccsoc_pkg::RST_FULL_MA, hold_min: ccsoc_pkg::RST_HOLD_MIN,
                empty_mv: ccsoc_pkg::RST_EMPTY_MV, top_mv: ccsoc_pkg::RST_TOP_MV,
                soc_min: ccsoc_pkg::RST_FLOOR, soc_max: ccsoc_pkg::RST_CEILING};
        gauge_soc      = '0;
        gauge_last_ms  = '0;
        gauge_prev_ma  = '0;
        gauge_tracking = 1'b0;
        gauge_track_t0 = '0;
        gauge_recal    = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_register_extremes();
        test_random_traffic();
        test_unbroken_stream();

        // Let any stray result surface before judging
        repeat (64) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("coulomb_counter_soc test passed");
        end else begin
            $display("coulomb_counter_soc test failed");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #20ms;
        $display("coulomb_counter_soc test failed");
        $finish;
    end

endmodule
